FILE: hdl/prac_pkg.sv
package prac_pkg;

  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CENTER_X = 3'd0,
    REG_CENTER_Y = 3'd1,
    REG_CENTER_Z = 3'd2,
    REG_ANGLE_X  = 3'd3,
    REG_ANGLE_Y  = 3'd4,
    REG_ANGLE_Z  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_in_t;

  typedef struct packed {
    logic signed [31:0] rotated_x;
    logic signed [31:0] rotated_y;
    logic signed [31:0] rotated_z;
  } point_out_t;

  // sine and cosine, Q2.15 signed
  typedef struct packed {
    logic signed [16:0] s;
    logic signed [16:0] c;
  } trig_t;

endpackage

FILE: hdl/prac_trig.sv
// Registered sine/cosine of one binary angle from a quarter-wave table.
module prac_trig
  import prac_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic [15:0] angle,
  output trig_t       trig_r
);

  localparam int DW = $clog2(SINE_TABLE_DEPTH) + 1;

  logic [15:0] tab [SINE_TABLE_DEPTH+1];

  // Taylor series, same integer steps as the Q2.30 build
  function automatic logic [15:0] sine_entry(input int k);
    logic [63:0] x, x2, term;
    longint sum, e;
    x = (64'd1686629713 * 64'(k)) / 64'(SINE_TABLE_DEPTH);
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / 64'((2*n) * (2*n + 1));
      if (n % 2 == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    e = (sum + 16384) >>> 15;
    if (e > 32767) e = 32767;
    return e[15:0];
  endfunction

  for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_tab
    assign tab[k] = sine_entry(k);
  end

  function automatic logic signed [16:0] lookup(input logic [15:0] a);
    logic [1:0] q;
    logic [14:0] r;
    logic [14+DW:0] prod;
    logic [DW-1:0] idx;
    logic signed [16:0] v;
    q = a[15:14];
    r = {1'b0, a[13:0]};
    if (q[0]) r = 15'd16384 - r;
    prod = (14+DW+1)'(r) * (14+DW+1)'(SINE_TABLE_DEPTH);
    idx = prod[14+DW-1:14];
    v = {1'b0, tab[idx]};
    return q[1] ? -v : v;
  endfunction

  always_ff @(posedge clk) begin
    trig_r.s <= lookup(angle);
    trig_r.c <= lookup(angle + 16'd16384);
  end

endmodule

FILE: hdl/prac_rot.sv
// One plane rotation: a = round(u*c - v*s), b = round(v*c + u*s), two stages.
module prac_rot
  import prac_pkg::*;
#(
  parameter int IW = 34
) (
  input  logic                 clk,
  input  logic signed [IW-1:0] u,
  input  logic signed [IW-1:0] v,
  input  trig_t                trig,
  output logic signed [IW-1:0] a_r,
  output logic signed [IW-1:0] b_r
);

  localparam int PW = IW + 17;

  logic signed [PW-1:0] uc_r, vs_r, vc_r, us_r;
  logic signed [PW:0] a_sum, b_sum;

  always_ff @(posedge clk) begin
    uc_r <= PW'(u) * PW'(trig.c);
    vs_r <= PW'(v) * PW'(trig.s);
    vc_r <= PW'(v) * PW'(trig.c);
    us_r <= PW'(u) * PW'(trig.s);
  end

  assign a_sum = (PW+1)'(uc_r) - (PW+1)'(vs_r) + (PW+1)'(16384);
  assign b_sum = (PW+1)'(vc_r) + (PW+1)'(us_r) + (PW+1)'(16384);

  always_ff @(posedge clk) begin
    a_r <= IW'(a_sum >>> 15);
    b_r <= IW'(b_sum >>> 15);
  end

endmodule

FILE: hdl/point_rotate_about_center_core.sv
// channel | signals                        | handshake
// input   | in_start, in_busy, in_point    | taken when in_start && !in_busy
// result  | out_strobe, out_point          | one cycle per strobe, no stall
// config  | cfg_we, cfg_index, cfg_data    | written when cfg_we
// One point per cycle; the pipe is offset, three rotations of two
// stages each, saturation. in_busy is always low. rst_n (synchronous)
// clears the valid pipe and the config registers. The receiver cannot stall.
module point_rotate_about_center_core
  import prac_pkg::*;
#(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_start,
  output logic                in_busy,
  input  point_in_t           in_point,
  output logic                out_strobe,
  output point_out_t          out_point,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int IW = 36;
  localparam int Lat = 8;

  logic signed [31:0] cx_r, cy_r, cz_r;
  logic [15:0] ax_r, ay_r, az_r;
  trig_t tx, ty, tz;
  logic [Lat-1:0] vld_r;
  logic signed [IW-1:0] x0_r, y0_r, z0_r;
  logic signed [IW-1:0] y1, z1, z2, x2, x3, y3;
  logic signed [IW-1:0] xd1_r, xd2_r, z2d1_r, z2d2_r, y1d1_r, y1d2_r;
  logic signed [IW:0] fx, fy, fz;
  point_out_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0; cy_r <= '0; cz_r <= '0;
      ax_r <= '0; ay_r <= '0; az_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X: cx_r <= cfg_data;
        REG_CENTER_Y: cy_r <= cfg_data;
        REG_CENTER_Z: cz_r <= cfg_data;
        REG_ANGLE_X:  ax_r <= cfg_data[15:0];
        REG_ANGLE_Y:  ay_r <= cfg_data[15:0];
        REG_ANGLE_Z:  az_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  prac_trig #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_tx (.clk, .angle(ax_r), .trig_r(tx));
  prac_trig #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_ty (.clk, .angle(ay_r), .trig_r(ty));
  prac_trig #(.SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_tz (.clk, .angle(az_r), .trig_r(tz));

  assign in_busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else vld_r <= {vld_r[Lat-2:0], in_start && !in_busy};
  end

  always_ff @(posedge clk) begin
    x0_r <= IW'(in_point.point_x) - IW'(cx_r);
    y0_r <= IW'(in_point.point_y) - IW'(cy_r);
    z0_r <= IW'(in_point.point_z) - IW'(cz_r);
    xd1_r <= x0_r;
    xd2_r <= xd1_r;
    y1d1_r <= y1;
    y1d2_r <= y1d1_r;
    z2d1_r <= z2;
    z2d2_r <= z2d1_r;
  end

  prac_rot #(.IW(IW)) u_rx (.clk, .u(y0_r), .v(z0_r), .trig(tx), .a_r(y1), .b_r(z1));
  prac_rot #(.IW(IW)) u_ry (.clk, .u(z1), .v(xd2_r), .trig(ty), .a_r(z2), .b_r(x2));
  prac_rot #(.IW(IW)) u_rz (.clk, .u(x2), .v(y1d2_r), .trig(tz), .a_r(x3), .b_r(y3));

  function automatic logic [31:0] sat(input logic signed [IW:0] v);
    if (v > (IW+1)'(64'sd2147483647)) return 32'h7fffffff;
    if (v < -(IW+1)'(64'sd2147483648)) return 32'h80000000;
    return v[31:0];
  endfunction

  assign fx = (IW+1)'(x3) + (IW+1)'(cx_r);
  assign fy = (IW+1)'(y3) + (IW+1)'(cy_r);
  assign fz = (IW+1)'(z2d2_r) + (IW+1)'(cz_r);

  always_ff @(posedge clk) begin
    out_r.rotated_x <= sat(fx);
    out_r.rotated_y <= sat(fy);
    out_r.rotated_z <= sat(fz);
  end

  assign out_strobe = vld_r[Lat-1];
  assign out_point = out_r;

  a_no_busy: assert property (@(posedge clk) in_busy == 1'b0)
    else $error("busy raised");
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[0] |-> ##(Lat-1) out_strobe)
    else $error("result lost");
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_strobe)
    else $error("strobe after reset");

endmodule

FILE: bench/rotate_checker.sv
module rotate_checker
  import prac_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_start,
  input  logic                in_busy,
  input  point_in_t           in_point,
  input  logic                out_strobe,
  input  point_out_t          out_point,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  output int                  fail_count,
  output int                  pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Depth = 256;

  longint     sine_lut[Depth+1];
  longint     ctr_x, ctr_y, ctr_z;
  logic [15:0] ang_x, ang_y, ang_z;
  point_out_t rotated_q[$];

  function automatic longint table_sine(int unsigned k);
    longint unsigned x, x2, term;
    longint sum, e;
    x = (64'd1686629713 * k) / Depth;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
      if (n % 2 == 1) sum -= longint'(term);
      else sum += longint'(term);
    end
    if (sum < 0) sum = 0;
    e = (sum + 16384) >>> 15;
    if (e > 32767) e = 32767;
    return e;
  endfunction

  function automatic longint bam_sine(logic [15:0] a);
    int unsigned q, r, idx;
    q = a[15:14];
    r = a[13:0];
    if (q[0]) r = 16384 - r;
    idx = (r * Depth) >> 14;
    if (idx > Depth) idx = Depth;
    return q[1] ? -sine_lut[idx] : sine_lut[idx];
  endfunction

  function automatic longint round_q15(longint v);
    return (v + 16384) >>> 15;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic point_out_t rotate_point(point_in_t p);
    longint x, y, z, y1, z1, z2, x2, x3, y3, cx, sx, cy, sy, cz, sz;
    point_out_t r;
    x = longint'(p.point_x) - ctr_x;
    y = longint'(p.point_y) - ctr_y;
    z = longint'(p.point_z) - ctr_z;
    cx = bam_sine(ang_x + 16'h4000); sx = bam_sine(ang_x);
    cy = bam_sine(ang_y + 16'h4000); sy = bam_sine(ang_y);
    cz = bam_sine(ang_z + 16'h4000); sz = bam_sine(ang_z);
    y1 = round_q15(y * cx - z * sx);
    z1 = round_q15(z * cx + y * sx);
    z2 = round_q15(z1 * cy - x * sy);
    x2 = round_q15(x * cy + z1 * sy);
    x3 = round_q15(x2 * cz - y1 * sz);
    y3 = round_q15(y1 * cz + x2 * sz);
    r.rotated_x = clamp32(x3 + ctr_x);
    r.rotated_y = clamp32(y3 + ctr_y);
    r.rotated_z = clamp32(z2 + ctr_z);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial begin
    for (int k = 0; k <= Depth; k++) sine_lut[k] = table_sine(k);
    fail_count = 0;
  end

  assign pending = rotated_q.size();

  always @(posedge clk) begin
    point_out_t want;
    if (!rst_n) begin
      ctr_x <= 0; ctr_y <= 0; ctr_z <= 0;
      ang_x <= '0; ang_y <= '0; ang_z <= '0;
    end else begin
      if (out_strobe) begin
        if (rotated_q.size() == 0) begin
          $display("MISMATCH unexpected transaction at %0t", $time);
          fail_count++;
        end else begin
          want = rotated_q.pop_front();
          if (out_point.rotated_x !== want.rotated_x)
            report_mismatch("rotated_x", out_point.rotated_x, want.rotated_x);
          if (out_point.rotated_y !== want.rotated_y)
            report_mismatch("rotated_y", out_point.rotated_y, want.rotated_y);
          if (out_point.rotated_z !== want.rotated_z)
            report_mismatch("rotated_z", out_point.rotated_z, want.rotated_z);
        end
      end
      if (in_start && !in_busy) rotated_q.push_back(rotate_point(in_point));
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_CENTER_X: ctr_x <= longint'(signed'(cfg_data));
          REG_CENTER_Y: ctr_y <= longint'(signed'(cfg_data));
          REG_CENTER_Z: ctr_z <= longint'(signed'(cfg_data));
          REG_ANGLE_X:  ang_x <= cfg_data[15:0];
          REG_ANGLE_Y:  ang_y <= cfg_data[15:0];
          REG_ANGLE_Z:  ang_z <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end
endmodule

FILE: bench/testbench.sv
module testbench;
  import prac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 400000;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_start = 1'b0;
  logic                in_busy;
  point_in_t           in_point = '0;
  logic                out_strobe;
  point_out_t          out_point;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  int                  fail_count;
  int                  pending;
  int                  cycles = 0;
  int                  idle_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  point_rotate_about_center_core DUT (.*);

  rotate_checker checker_i (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 1) ? 32'h00010000 : 32'hffff0000;
      3: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)};
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_angle();
    case ($urandom_range(0, 4))
      0: return {16'h0, 16'(16'h4000 * $urandom_range(0, 3))};
      1: return $urandom_range(0, 1) ? 32'h7fff : 32'h8000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_start <= 1'b0;
      @(posedge clk);
    end
    in_start <= 1'b1;
    in_point <= '{point_x: x, point_y: y, point_z: z};
    @(posedge clk);
    while (in_busy) @(posedge clk);
  endtask

  task automatic settle();
    in_start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_rotation(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                              logic [31:0] ax, logic [31:0] ay, logic [31:0] az);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_ANGLE_X, ax);
    write_reg(REG_ANGLE_Y, ay);
    write_reg(REG_ANGLE_Z, az);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_point(32'h7fffffff, 32'h80000000, 32'h0);
    send_point(32'h00010000, 32'hffff0000, 32'h12345678);
    settle();
    set_rotation(32'h7fffffff, 32'h80000000, 32'h0, 32'h4000, 32'h8000, 32'hc000);
    send_point(32'h80000000, 32'h7fffffff, 32'h80000000);
    send_point(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_point(32'h0, 32'h0, 32'h0);
    settle();
    set_rotation(32'h80000000, 32'h7fffffff, 32'h00010000, 32'h7fff, 32'h8000, 32'h2000);
    send_point(32'h7fffffff, 32'h80000000, 32'h80000000);
    send_point(32'hffffffff, 32'h00000001, 32'h7fffffff);
    send_point(32'h00010000, 32'h00020000, 32'h00030000);
    settle();
    set_rotation(32'h0, 32'h0, 32'h0, 32'h1, 32'hffff, 32'h3fff);
    for (int i = 0; i < 8; i++) send_point(pick_coord(), pick_coord(), pick_coord());
    settle();

    for (int phase = 0; phase < 24; phase++) begin
      case (phase % 4)
        0: idle_pct = 0;
        1: idle_pct = 83;
        2: idle_pct = 6;
        default: idle_pct = $urandom_range(0, 50);
      endcase
      set_rotation(pick_coord(), pick_coord(), pick_coord(),
                   pick_angle(), pick_angle(), pick_angle());
      for (int i = 0; i < 56; i++) send_point(pick_coord(), pick_coord(), pick_coord());
      settle();
    end

    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
